### rtl/trs_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoid ramp setpoint package
// Shared widths, register indexes, payload types and controller types.
// ----------------------------------------------------------------------------
`default_nettype none

package trs_pkg;

  localparam int unsigned IO_W      = 32;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned HALF_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MAX         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL_MAX         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TWICE_DECEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANTICIPATION_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVAL_WINDOW    = 3'd5;

  typedef struct packed {
    logic signed [IO_W-1:0] target_pos;
    logic signed [IO_W-1:0] measured_pos;
    logic signed [IO_W-1:0] measured_speed;
  } trs_in_t;

  typedef struct packed {
    logic signed [IO_W-1:0] ramped_setpoint;
    logic                   reached;
  } trs_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_BRAKE,
    ST_SUM,
    ST_PIVOT,
    ST_CMD,
    ST_OUT
  } trs_state_e;

  typedef struct packed {
    logic load_in;
    logic step_mul1;
    logic step_mul2;
    logic step_brake;
    logic step_sum;
    logic step_pivot;
    logic step_cmd;
    logic step_out;
  } trs_cmd_t;

  typedef struct packed {
    logic out_free;
  } trs_status_t;

endpackage

`default_nettype wire

### rtl/trs_ctrl.sv
// ----------------------------------------------------------------------------
// Trapezoid ramp setpoint controller
// Sequences one item through the datapath steps and gates the output load.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire trs_pkg::trs_status_t  status_i,
  output trs_pkg::trs_cmd_t          cmd_o
);
  import trs_pkg::*;

  trs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_BRAKE;
      ST_BRAKE: state_d = ST_SUM;
      ST_SUM:   state_d = ST_PIVOT;
      ST_PIVOT: state_d = ST_CMD;
      ST_CMD:   state_d = ST_OUT;
      ST_OUT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_MUL1:  cmd_o.step_mul1  = 1'b1;
      ST_MUL2:  cmd_o.step_mul2  = 1'b1;
      ST_BRAKE: cmd_o.step_brake = 1'b1;
      ST_SUM:   cmd_o.step_sum   = 1'b1;
      ST_PIVOT: cmd_o.step_pivot = 1'b1;
      ST_CMD:   cmd_o.step_cmd   = 1'b1;
      ST_OUT:   cmd_o.step_out   = status_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/trs_dp.sv
// ----------------------------------------------------------------------------
// Trapezoid ramp setpoint datapath
// Configuration registers, split products, braking pivot, speed command and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_dp #(
  parameter int unsigned DW = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [trs_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  wire logic [trs_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  wire trs_pkg::trs_in_t                  in_data_i,
  input  wire trs_pkg::trs_cmd_t                 cmd_i,
  output trs_pkg::trs_status_t                   status_o,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output trs_pkg::trs_out_t                      out_data_o
);
  import trs_pkg::*;

  localparam int unsigned SQW        = DW - 1;
  localparam int unsigned PW         = ((DW > IO_W) ? DW : IO_W) + 2;
  localparam int unsigned OW         = (DW < IO_W) ? DW : IO_W;
  localparam int unsigned PROD_W     = 2 * HALF_W;
  localparam int unsigned SQ_RAW_W   = PROD_W - FRAC_BITS;
  localparam int unsigned PGAIN_W    = IO_W + CFG_W;
  localparam int unsigned GAIN_RAW_W = PGAIN_W - FRAC_BITS;
  localparam int unsigned PPART_W    = HALF_W + CFG_W;
  localparam int unsigned FULL_W     = PPART_W + HALF_W;
  localparam int unsigned M1_RAW_W   = FULL_W - FRAC_BITS;
  localparam int unsigned CMD_W      = IO_W + 2;

  localparam logic [SQW-1:0]          LIM  = {SQW{1'b1}};
  localparam logic signed [PW-1:0]    SMAX = signed'(PW'(LIM));
  localparam logic signed [PW-1:0]    SMIN = ~SMAX;
  localparam logic signed [CMD_W-1:0] OMAX = signed'({{(CMD_W - OW + 1){1'b0}},
                                                     {(OW - 1){1'b1}}});
  localparam logic signed [CMD_W-1:0] OMIN = ~OMAX;

  logic [CFG_W-1:0] accel_q, decel_q, inv_q, limit_q, gain_q, window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q  <= '0;
      decel_q  <= '0;
      inv_q    <= '0;
      limit_q  <= '0;
      gain_q   <= '0;
      window_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ACCEL_MAX:         accel_q  <= cfg_wdata_i;
        CFG_DECEL_MAX:         decel_q  <= cfg_wdata_i;
        CFG_INV_TWICE_DECEL:   inv_q    <= cfg_wdata_i;
        CFG_SPEED_LIMIT:       limit_q  <= cfg_wdata_i;
        CFG_ANTICIPATION_GAIN: gain_q   <= cfg_wdata_i;
        CFG_ARRIVAL_WINDOW:    window_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  logic signed [IO_W-1:0] tgt_q, pos_q, spd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      tgt_q <= in_data_i.target_pos;
      pos_q <= in_data_i.measured_pos;
      spd_q <= in_data_i.measured_speed;
    end
  end

  logic [IO_W-1:0]        spd_u, aspd;
  logic signed [IO_W:0]   diff;
  logic [IO_W:0]          adiff;
  logic [PROD_W-1:0]      psq_d, psq_q;
  logic [PGAIN_W-1:0]     pgain_d, pgain_q;
  logic                   fwd_q, reached_q;

  assign spd_u   = spd_q;
  assign aspd    = spd_q[IO_W-1] ? (~spd_u + IO_W'(1)) : spd_u;
  assign diff    = (IO_W + 1)'(tgt_q) - (IO_W + 1)'(pos_q);
  assign adiff   = diff[IO_W] ? unsigned'(-diff) : unsigned'(diff);
  assign psq_d   = PROD_W'(aspd) * PROD_W'(aspd);
  assign pgain_d = PGAIN_W'(aspd) * PGAIN_W'(gain_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_mul1) begin
      psq_q     <= psq_d;
      pgain_q   <= pgain_d;
      fwd_q     <= ~diff[IO_W];
      reached_q <= adiff < (IO_W + 1)'(window_q);
    end
  end

  logic [SQ_RAW_W-1:0]   sq_raw;
  logic [SQW-1:0]        sq_sat;
  logic [PROD_W-1:0]     sq_ext;
  logic [GAIN_RAW_W-1:0] gain_raw;
  logic [PPART_W-1:0]    plo_d, phi_d, plo_q, phi_q;
  logic [SQW-1:0]        m2_d, m2_q;

  assign sq_raw   = psq_q[PROD_W-1:FRAC_BITS];
  assign sq_sat   = (sq_raw > SQ_RAW_W'(LIM)) ? LIM : sq_raw[SQW-1:0];
  assign sq_ext   = PROD_W'(sq_sat);
  assign plo_d    = PPART_W'(sq_ext[HALF_W-1:0]) * PPART_W'(inv_q);
  assign phi_d    = PPART_W'(sq_ext[PROD_W-1:HALF_W]) * PPART_W'(inv_q);
  assign gain_raw = pgain_q[PGAIN_W-1:FRAC_BITS];
  assign m2_d     = (gain_raw > GAIN_RAW_W'(LIM)) ? LIM : gain_raw[SQW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_mul2) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      m2_q  <= m2_d;
    end
  end

  logic [FULL_W-1:0]   full;
  logic [M1_RAW_W-1:0] m1_raw;
  logic [SQW-1:0]      m1_d, m1_q;

  assign full   = {phi_q, {HALF_W{1'b0}}} + FULL_W'(plo_q);
  assign m1_raw = full[FULL_W-1:FRAC_BITS];
  assign m1_d   = (m1_raw > M1_RAW_W'(LIM)) ? LIM : m1_raw[SQW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_brake) begin
      m1_q <= m1_d;
    end
  end

  logic [SQW:0]   bsum;
  logic [SQW-1:0] brake_q;

  assign bsum = {1'b0, m1_q} + {1'b0, m2_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_sum) begin
      brake_q <= bsum[SQW] ? LIM : bsum[SQW-1:0];
    end
  end

  logic signed [PW-1:0] tgt_w, pos_w, brake_w, piv, piv_sat;
  logic                 ge_q;

  assign tgt_w   = PW'(tgt_q);
  assign pos_w   = PW'(pos_q);
  assign brake_w = signed'(PW'(brake_q));
  assign piv     = spd_q[IO_W-1] ? (tgt_w + brake_w) : (tgt_w - brake_w);
  assign piv_sat = (piv > SMAX) ? SMAX : ((piv < SMIN) ? SMIN : piv);

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_pivot) begin
      ge_q <= piv_sat >= pos_w;
    end
  end

  logic [CFG_W-1:0]         acc_mag;
  logic signed [CMD_W-1:0]  acc, csum, limp, limn, cmd_c;
  logic signed [IO_W-1:0]   sc_q, cmd_q;

  assign acc_mag = (ge_q == fwd_q) ? accel_q : decel_q;
  assign acc     = ge_q ? signed'(CMD_W'(acc_mag)) : -signed'(CMD_W'(acc_mag));
  assign csum    = CMD_W'(sc_q) + acc;
  assign limp    = signed'(CMD_W'(limit_q));
  assign limn    = -limp;
  assign cmd_c   = (csum > limp) ? limp : ((csum < limn) ? limn : csum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0;
    end else if (cmd_i.step_cmd) begin
      sc_q <= reached_q ? '0 : cmd_c[IO_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_cmd) begin
      cmd_q <= cmd_c[IO_W-1:0];
    end
  end

  logic signed [CMD_W-1:0] rsum, rsat;
  logic                    out_valid_q;
  trs_out_t                out_q;

  assign rsum = CMD_W'(pos_q) + CMD_W'(cmd_q);
  assign rsat = (rsum > OMAX) ? OMAX : ((rsum < OMIN) ? OMIN : rsum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_out) begin
      out_q.ramped_setpoint <= reached_q ? tgt_q : rsat[IO_W-1:0];
      out_q.reached         <= reached_q;
    end
  end

  assign status_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

### rtl/trapezoid_ramp_setpoint.sv
// ----------------------------------------------------------------------------
// Trapezoid ramp setpoint generator
// One ramped position setpoint per control tick from target, position and
// speed, with a kept speed command and a braking pivot.
//
// Usage: the input channel carries target, measured position and measured
// speed; the output channel carries the ramped setpoint and the reached flag.
// Both are valid/ready. The user writes registers through the plain write port
// only while no item is in flight; the block itself does not enforce this.
// An item runs through the transfer in and seven sequencer steps (two product
// steps on 32 by 32 bit multipliers, the partial-product merge, the brake sum,
// the pivot compare, the speed command update, the output load). The input
// stays closed until the item has passed its output load, so a new input
// transfer only follows once the previous item is through.
// The output register holds the result until its transfer; the next item runs
// up to its output step meanwhile and waits there while the receiver stalls.
// Reset clears the registers, the speed command and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_ramp_setpoint #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [trs_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [trs_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire trs_pkg::trs_in_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output trs_pkg::trs_out_t                   out_data_o
);
  import trs_pkg::*;

  trs_cmd_t    cmd;
  trs_status_t status;

  trs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  trs_dp #(
    .DW (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/trs_checker.sv
// ----------------------------------------------------------------------------
// Trapezoid ramp setpoint checker
// Port-level checks of the handshake and the item sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire trs_pkg::trs_out_t out_data_o
);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // An accepted item keeps the input closed; checked at the sequencer's first step and again at a later step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##5 !in_ready_o)
    else $error("input reopened while an item was in flight");

  // A result appears only at the end of an item's processing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an item in flight");

endmodule

bind trapezoid_ramp_setpoint trs_checker u_trs_checker (.*);

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// Trapezoid ramp setpoint testbench
// Drives control ticks through the valid/ready input channel, predicts each
// ramped setpoint and reached flag with a cycle-free model of the ramp, and
// checks every output transfer in order. Runs directed corner ticks, then
// random phases of noise and converging trajectories under several register
// settings, with random idling on both channels and one long receiver stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import trs_pkg::*;

  localparam longint DW_MAX      = 64'sd2147483647;
  localparam longint DW_MIN      = -DW_MAX - 1;
  localparam int     IDLE_LIMIT  = 4000;
  localparam int     HOLD_CYCLES = 600;
  localparam int     HOLD_AFTER  = 400;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i  = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  trs_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  trs_out_t             out_data_o;

  trapezoid_ramp_setpoint DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  trs_in_t  pending_ticks[$];
  trs_out_t expected_setpoints[$];

  longint accel_q  = 0;
  longint decel_q  = 0;
  longint inv2d_q  = 0;
  longint vlim_q   = 0;
  longint gain_q   = 0;
  longint window_q = 0;
  longint speed_cmd_q = 0;

  int  err_cnt      = 0;
  int  ticks_in     = 0;
  int  idle_cycles  = 0;
  int  send_gap     = 0;
  int  stall_left   = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  bit  no_idle      = 1'b0;
  bit  in_fire      = 1'b0;

  function automatic longint sat_dw(longint x);
    if (x > DW_MAX) return DW_MAX;
    if (x < DW_MIN) return DW_MIN;
    return x;
  endfunction

  function automatic longint mul_q(longint a, longint b);
    longint p;
    p = (a * b) >>> FRAC_BITS;
    return (p > DW_MAX) ? DW_MAX : p;
  endfunction

  function automatic trs_out_t predict_setpoint(trs_in_t it);
    longint   tgt, pos, spd, diff, aspd, sq, brake, pivot, acc, cmd, res;
    trs_out_t o;
    tgt   = longint'(it.target_pos);
    pos   = longint'(it.measured_pos);
    spd   = longint'(it.measured_speed);
    diff  = tgt - pos;
    aspd  = (spd < 0) ? -spd : spd;
    sq    = mul_q(aspd, aspd);
    brake = sat_dw(mul_q(sq, inv2d_q) + mul_q(aspd, gain_q));
    pivot = sat_dw((spd >= 0) ? tgt - brake : tgt + brake);
    if (pivot >= pos) begin
      acc = (diff >= 0) ? accel_q : decel_q;
    end else begin
      acc = (diff >= 0) ? -decel_q : -accel_q;
    end
    cmd = speed_cmd_q + acc;
    if (cmd > vlim_q) cmd = vlim_q;
    if (cmd < -vlim_q) cmd = -vlim_q;
    speed_cmd_q = cmd;
    if (((diff < 0) ? -diff : diff) < window_q) begin
      speed_cmd_q = 0;
      o.reached   = 1'b1;
      res         = tgt;
    end else begin
      o.reached   = 1'b0;
      res         = sat_dw(pos + cmd);
    end
    o.ramped_setpoint = res[31:0];
    return o;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Input side: offer the next tick once the current one has been transferred.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (pending_ticks.size() != 0) begin
        in_data_i  <= pending_ticks.pop_front();
        in_valid_i <= 1'b1;
        send_gap   <= draw_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side: random stalls plus one long hold-off that backs up the block.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left   <= hold_left - 1;
      end else if (!hold_done && ticks_in >= HOLD_AFTER) begin
        hold_done   <= 1'b1;
        hold_left   <= HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else begin
        out_ready_i <= 1'b1;
        stall_left  <= draw_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    trs_out_t want;
    if (rst_ni) begin
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        expected_setpoints.push_back(predict_setpoint(in_data_i));
        ticks_in <= ticks_in + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_setpoints.size() == 0) begin
          if (err_cnt < 10) begin
            $display("unexpected output transfer: setpoint %h reached %b",
                     out_data_o.ramped_setpoint, out_data_o.reached);
          end
          err_cnt <= err_cnt + 1;
        end else begin
          want = expected_setpoints.pop_front();
          if (out_data_o.ramped_setpoint !== want.ramped_setpoint ||
              out_data_o.reached !== want.reached) begin
            if (err_cnt < 10) begin
              $display("mismatch: setpoint exp %h got %h, reached exp %b got %b",
                       want.ramped_setpoint, out_data_o.ramped_setpoint,
                       want.reached, out_data_o.reached);
            end
            err_cnt <= err_cnt + 1;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_tick(longint tgt, longint pos, longint spd);
    trs_in_t it;
    it.target_pos     = tgt[31:0];
    it.measured_pos   = pos[31:0];
    it.measured_speed = spd[31:0];
    pending_ticks.push_back(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ACCEL_MAX:         accel_q  = longint'(val);
      CFG_DECEL_MAX:         decel_q  = longint'(val);
      CFG_INV_TWICE_DECEL:   inv2d_q  = longint'(val);
      CFG_SPEED_LIMIT:       vlim_q   = longint'(val);
      CFG_ANTICIPATION_GAIN: gain_q   = longint'(val);
      CFG_ARRIVAL_WINDOW:    window_q = longint'(val);
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [CFG_W-1:0] acc, logic [CFG_W-1:0] dec,
                           logic [CFG_W-1:0] inv, logic [CFG_W-1:0] lim,
                           logic [CFG_W-1:0] gain, logic [CFG_W-1:0] win, bit junk);
    write_reg(CFG_ACCEL_MAX, acc);
    write_reg(CFG_DECEL_MAX, dec);
    write_reg(CFG_INV_TWICE_DECEL, inv);
    write_reg(CFG_SPEED_LIMIT, lim);
    write_reg(CFG_ANTICIPATION_GAIN, gain);
    write_reg(CFG_ARRIVAL_WINDOW, win);
    if (junk) begin
      write_reg(CFG_ARRIVAL_WINDOW + 3'd1, '1);
      write_reg(CFG_ARRIVAL_WINDOW + 3'd2, '1);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || in_valid_i || expected_setpoints.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (12) @(negedge clk_i);
  endtask

  // Converging moves toward a held target, mixed with a given share of full-range noise.
  task automatic queue_moves(int n, int noise_pct, longint span);
    longint tgt, pos, spd, v;
    int     seg_left;
    seg_left = 0;
    tgt = 0;
    pos = 0;
    spd = 0;
    for (int k = 0; k < n; k++) begin
      if (seg_left == 0) begin
        tgt = longint'($urandom_range(0, 32'(2 * span))) - span;
        pos = longint'($urandom_range(0, 32'(2 * span))) - span;
        spd = longint'($urandom_range(0, 32'(span / 32))) - span / 64;
        seg_left = $urandom_range(10, 40);
      end
      seg_left--;
      if ($urandom_range(0, 99) < noise_pct) begin
        push_tick(longint'($urandom), longint'($urandom), longint'($urandom));
      end else begin
        push_tick(tgt, pos, spd);
        v = (tgt - pos) / 8;
        if (v > span / 16) v = span / 16;
        if (v < -span / 16) v = -span / 16;
        spd = v + longint'($urandom_range(0, 64)) - 32;
        pos = pos + spd;
        if ($urandom_range(0, 19) == 0) pos = tgt + longint'($urandom_range(0, 8)) - 4;
      end
    end
  endtask

  task automatic load_motion_regs();
    load_regs(CFG_W'($urandom_range(32'h200, 32'h4_0000)),
              CFG_W'($urandom_range(32'h200, 32'h4_0000)),
              CFG_W'($urandom_range(0, 32'h1_0000)),
              CFG_W'($urandom_range(32'h1000, 32'h40_0000)),
              CFG_W'($urandom_range(0, 32'h1_0000)),
              CFG_W'($urandom_range(0, 32'h4_0000)), 1'b0);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_tick(0, 0, 0);
    push_tick(5, 0, 0);
    push_tick(DW_MAX, DW_MIN, DW_MAX);
    push_tick(DW_MIN, DW_MAX, DW_MIN);
    drain();

    load_regs(31'h8000, 31'h1_0000, 31'h8000, 31'h10_0000, 31'h1000, 31'h1_0000, 1'b1);
    push_tick(0, 0, 0);
    push_tick(32'h1_0000, 0, 0);
    push_tick(32'hFFFF, 0, 0);
    push_tick(-32'sh1_0000, 0, 0);
    push_tick(-32'shFFFF, 0, 0);
    push_tick(DW_MAX, DW_MIN, 0);
    push_tick(DW_MIN, DW_MAX, 0);
    push_tick(DW_MAX, DW_MAX, DW_MAX);
    push_tick(DW_MIN, DW_MIN, DW_MIN);
    push_tick(32'h10_0000, 0, 32'h2_0000);
    push_tick(32'h10_0000, 32'hF_0000, 32'h4_0000);
    push_tick(-32'sh10_0000, 0, -32'sh2_0000);
    push_tick(-32'sh10_0000, -32'shF_0000, -32'sh4_0000);
    push_tick(DW_MAX, 0, DW_MIN);
    push_tick(DW_MIN, 0, DW_MAX);
    push_tick(DW_MAX, DW_MIN, DW_MAX);
    push_tick(DW_MIN, DW_MAX, DW_MIN);
    push_tick(32'h100, 32'h20_0000, 0);
    drain();

    load_regs('1, '1, '1, '1, '1, '1, 1'b0);
    push_tick(DW_MAX, DW_MIN, 0);
    push_tick(DW_MIN, DW_MAX, DW_MIN);
    push_tick(0, 32'h7000_0000, 32'h1_0000);
    queue_moves(150, 100, 64'sd1 << 28);
    drain();

    load_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
              CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), 1'b0);
    queue_moves(150, 50, 64'sd1 << 28);
    drain();

    load_motion_regs();
    queue_moves(250, 15, 64'sd1 << 24);
    drain();

    load_motion_regs();
    no_idle = 1'b1;
    queue_moves(200, 10, 64'sd1 << 20);
    drain();
    no_idle = 1'b0;

    load_regs('0, '0, CFG_W'($urandom), '1, CFG_W'($urandom), '0, 1'b0);
    queue_moves(150, 20, 64'sd1 << 26);
    drain();

    load_motion_regs();
    queue_moves(250, 20, 64'sd1 << 24);
    drain();

    if (err_cnt == 0 && expected_setpoints.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
